[hw/rtl/kfsp_pkg.sv]
// Shared types, codes and helpers for the keyframe spline pose player.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package kfsp_pkg;

   localparam int MAX_KEYS_DEF = 64;

   localparam logic [2:0] OPC_CLEAR  = 3'd0;
   localparam logic [2:0] OPC_APPEND = 3'd1;
   localparam logic [2:0] OPC_SAMPLE = 3'd2;
   localparam logic [2:0] OPC_START  = 3'd3;
   localparam logic [2:0] OPC_TICK   = 3'd4;

   localparam logic CSR_PLAY_SPEED  = 1'b0;
   localparam logic CSR_LOOP_ENABLE = 1'b1;

   localparam logic [14:0] PLAY_SPEED_RST = 15'd4096;

   localparam logic signed [35:0] DEG180 = 36'sd11796480;
   localparam logic signed [35:0] DEG360 = 36'sd23592960;

   // 360 deg is 45 << 19; floor(m / 45) = (m * UNW_RECIP) >> 20 for m < 2^16
   localparam logic [14:0] UNW_RECIP = 15'd23302;

   localparam int DIV_DVD_W = 48;
   localparam int DIV_DSR_W = 32;

   typedef enum logic [2:0] {
      CMD_CLEAR,
      CMD_APPEND,
      CMD_SAMPLE,
      CMD_START,
      CMD_TICK,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [31:0]        time_value;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [24:0] heading;
      logic signed [23:0] tilt;
      logic [23:0]        view;
      logic               allow;
   } cmd_type;

   typedef struct packed {
      logic [31:0] t;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] heading;
      logic [31:0] tilt;
      logic [31:0] view;
   } key_entry_type;

   typedef struct packed {
      logic [14:0] speed;
      logic        loop_en;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UNW_WAIT,
      ST_UNW_FIX,
      ST_WRITE,
      ST_TICK0,
      ST_TICK1,
      ST_MOD_WAIT,
      ST_SMP0,
      ST_SMP1,
      ST_SMP2,
      ST_SRCH,
      ST_U_WAIT,
      ST_F0,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_F4,
      ST_SPL_INIT,
      ST_SPL_MUL,
      ST_SPL_ADD,
      ST_RESP
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] chan_sel(input key_entry_type e,
                                                   input logic [2:0] ch);
      logic [31:0] r;
      unique case (ch)
         3'd0: r = e.x;
         3'd1: r = e.y;
         3'd2: r = e.z;
         3'd3: r = e.heading;
         3'd4: r = e.tilt;
         default: r = e.view;
      endcase
      return $signed(r);
   endfunction

endpackage

[hw/rtl/kfsp_front.sv]
// Front end: accepts request transactions, classifies the operation and
// queues commands two deep for the back end. Uses kfsp_pkg.
`timescale 1ns / 1ps
module kfsp_front
   import kfsp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic [31:0]        req_time_value,
   input  logic signed [31:0] req_key_x,
   input  logic signed [31:0] req_key_y,
   input  logic signed [31:0] req_key_z,
   input  logic signed [24:0] req_key_heading,
   input  logic signed [23:0] req_key_tilt,
   input  logic [23:0]        req_key_view_angle,
   input  logic               req_allow_play,
   input  logic               q_pop,
   output logic               q_valid,
   output cmd_type            q_head
);

   cmd_type      entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;
   cmd_type      cmd;
   cmd_kind_type kind;

   always_comb begin
      unique case (req_operation)
         OPC_CLEAR:  kind = CMD_CLEAR;
         OPC_APPEND: kind = CMD_APPEND;
         OPC_SAMPLE: kind = CMD_SAMPLE;
         OPC_START:  kind = CMD_START;
         OPC_TICK:   kind = CMD_TICK;
         default:    kind = CMD_NOP;
      endcase
      cmd.kind       = kind;
      cmd.time_value = req_time_value;
      cmd.x          = req_key_x;
      cmd.y          = req_key_y;
      cmd.z          = req_key_z;
      cmd.heading    = req_key_heading;
      cmd.tilt       = req_key_tilt;
      cmd.view       = req_key_view_angle;
      cmd.allow      = req_allow_play;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

[hw/rtl/kfsp_div.sv]
// Restoring divider, one quotient bit per cycle, 48-bit dividend by
// 32-bit divisor. Uses kfsp_pkg for its widths.
`timescale 1ns / 1ps
module kfsp_div
   import kfsp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_DVD_W-1:0] dividend,
   input  logic [DIV_DSR_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_DVD_W-1:0] quotient,
   output logic [DIV_DSR_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DIV_DVD_W + 1);

   logic [DIV_DSR_W-1:0] rem_ff, rem_in;
   logic [DIV_DVD_W-1:0] quo_ff, quo_in;
   logic [DIV_DSR_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_DSR_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_DVD_W-1]};
      fits   = (trial >= {1'b0, dsr_ff});
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CNT_W'(DIV_DVD_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? DIV_DSR_W'(trial - {1'b0, dsr_ff}) : trial[DIV_DSR_W-1:0];
         quo_in  = {quo_ff[DIV_DVD_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[hw/rtl/kfsp_back.sv]
// Back end: key table memory, playhead state, segment search, spline
// evaluation and the response register. Uses kfsp_pkg and kfsp_div.
`timescale 1ns / 1ps
module kfsp_back
   import kfsp_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEF,
   localparam int AW = $clog2(MAX_KEYS),
   localparam int CW = $clog2(MAX_KEYS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_valid,
   input  cmd_type            q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_pose_valid,
   output logic signed [31:0] rsp_pose_x,
   output logic signed [31:0] rsp_pose_y,
   output logic signed [31:0] rsp_pose_z,
   output logic signed [31:0] rsp_pose_heading,
   output logic signed [31:0] rsp_pose_tilt,
   output logic signed [31:0] rsp_pose_view_angle,
   output logic [31:0]        rsp_playhead,
   output logic               rsp_is_playing,
   output logic [CW-1:0]      rsp_key_total
);

   key_entry_type mem [MAX_KEYS];
   key_entry_type rd_ff;
   logic [AW-1:0] raddr;
   logic          mem_we;
   key_entry_type wdata;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CW-1:0]      kc_ff, kc_in;
   logic [31:0]        pt_ff, pt_in;
   logic               play_ff, play_in;
   logic signed [31:0] lasthd_ff, lasthd_in;
   logic signed [35:0] yw_ff, yw_in;
   logic               unw_neg_ff, unw_neg_in;
   logic [15:0]        unw_m_ff, unw_m_in;
   logic [10:0]        unw_q_ff, unw_q_in;
   logic [34:0]        adv_ff, adv_in;
   logic [31:0]        t_ff, t_in;
   logic [31:0]        prev_t_ff, prev_t_in;
   logic [AW-1:0]      seg_ff, seg_in;
   logic [15:0]        u_ff, u_in;
   key_entry_type      p_ff [4];
   key_entry_type      p_in [4];
   logic [2:0]         ch_ff, ch_in;
   logic [1:0]         step_ff, step_in;
   logic signed [38:0] acc_ff, acc_in;
   logic signed [55:0] prod_ff, prod_in;
   logic signed [31:0] pose_ff [6];
   logic signed [31:0] pose_in [6];
   logic               pvalid_ff, pvalid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;
   logic               rsp_pvalid_ff;
   logic signed [31:0] rsp_pose_ff [6];
   logic [31:0]        rsp_pt_ff;
   logic               rsp_play_ff;
   logic [CW-1:0]      rsp_kc_ff;

   logic                 div_start;
   logic [DIV_DVD_W-1:0] div_dvd;
   logic [DIV_DSR_W-1:0] div_dsr;
   logic                 div_done;
   logic [DIV_DVD_W-1:0] div_quo;
   logic [DIV_DSR_W-1:0] div_rem;

   logic [CW-1:0]      kcm1;
   logic [CW:0]        seg_p2;
   logic signed [35:0] y36;
   logic signed [35:0] dhd;
   logic signed [35:0] exc_hi;
   logic signed [35:0] exc_lo;
   logic [30:0]        unw_qprod;
   logic [35:0]        qmul;
   logic signed [35:0] yfix;
   logic signed [31:0] hd_sat;
   logic [46:0]        tprod;
   logic [35:0]        tsum;
   logic signed [35:0] pa, pb, pc, pd;
   logic signed [35:0] c0, c1, c2, c3;
   logic signed [35:0] coef;
   logic signed [55:0] sh;
   logic signed [38:0] acc_new;
   logic signed [38:0] acc_half;

   kfsp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      kcm1      = kc_ff - CW'(1);
      seg_p2    = (CW + 1)'(seg_ff) + (CW + 1)'(2);
      y36       = 36'(cmd_ff.heading);
      dhd       = y36 - 36'(lasthd_ff);
      exc_hi    = dhd - DEG180 + DEG360 - 36'sd1;
      exc_lo    = -DEG180 - dhd + DEG360 - 36'sd1;
      unw_qprod = 31'(unw_m_ff) * 31'(UNW_RECIP);
      qmul      = 36'(unw_q_ff) * 36'(DEG360);
      yfix      = unw_neg_ff ? yw_ff + $signed(qmul) : yw_ff - $signed(qmul);
      hd_sat    = sat32(40'(yw_ff));
      tprod     = 47'(cmd_ff.time_value) * 47'(cfg.speed);
      tsum      = 36'(pt_ff) + 36'(adv_ff);
      pa        = 36'(chan_sel(p_ff[0], ch_ff));
      pb        = 36'(chan_sel(p_ff[1], ch_ff));
      pc        = 36'(chan_sel(p_ff[2], ch_ff));
      pd        = 36'(chan_sel(p_ff[3], ch_ff));
      c0        = 36'sd2 * pb;
      c1        = pc - pa;
      c2        = 36'sd2 * pa - 36'sd5 * pb + 36'sd4 * pc - pd;
      c3        = -pa + 36'sd3 * pb - 36'sd3 * pc + pd;
      unique case (step_ff)
         2'd0:    coef = c2;
         2'd1:    coef = c1;
         default: coef = c0;
      endcase
      sh       = prod_ff >>> 16;
      acc_new  = 39'(sh) + 39'(coef);
      acc_half = acc_new >>> 1;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      kc_in      = kc_ff;
      pt_in      = pt_ff;
      play_in    = play_ff;
      lasthd_in  = lasthd_ff;
      yw_in      = yw_ff;
      unw_neg_in = unw_neg_ff;
      unw_m_in   = unw_m_ff;
      unw_q_in   = unw_q_ff;
      adv_in     = adv_ff;
      t_in       = t_ff;
      prev_t_in  = prev_t_ff;
      seg_in     = seg_ff;
      u_in       = u_ff;
      ch_in      = ch_ff;
      step_in    = step_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      pvalid_in  = pvalid_ff;
      for (int k = 0; k < 4; k++) begin
         p_in[k] = p_ff[k];
      end
      for (int k = 0; k < 6; k++) begin
         pose_in[k] = pose_ff[k];
      end
      q_pop     = 1'b0;
      raddr     = '0;
      mem_we    = 1'b0;
      wdata     = '0;
      div_start = 1'b0;
      div_dvd   = '0;
      div_dsr   = '0;
      rsp_load  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            pvalid_in = 1'b0;
            for (int k = 0; k < 6; k++) begin
               pose_in[k] = '0;
            end
            state_in = ST_RESP;
            unique case (cmd_ff.kind)
               CMD_CLEAR: begin
                  kc_in   = '0;
                  pt_in   = '0;
                  play_in = 1'b0;
               end
               CMD_APPEND: begin
                  if (kc_ff < CW'(MAX_KEYS)) begin
                     yw_in    = y36;
                     state_in = ST_WRITE;
                     if (kc_ff != '0) begin
                        if (dhd > DEG180) begin
                           unw_m_in   = exc_hi[34:19];
                           unw_neg_in = 1'b0;
                           state_in   = ST_UNW_WAIT;
                        end else if (dhd < -DEG180) begin
                           unw_m_in   = exc_lo[34:19];
                           unw_neg_in = 1'b1;
                           state_in   = ST_UNW_WAIT;
                        end
                     end
                  end
               end
               CMD_SAMPLE: begin
                  pt_in   = cmd_ff.time_value;
                  play_in = 1'b0;
                  if (kc_ff != '0) begin
                     t_in     = cmd_ff.time_value;
                     state_in = ST_SMP0;
                  end
               end
               CMD_START: begin
                  if (kc_ff >= CW'(2)) begin
                     play_in = 1'b1;
                     pt_in   = '0;
                  end
               end
               CMD_TICK: begin
                  if (cmd_ff.allow && play_ff && kc_ff >= CW'(2)) begin
                     state_in = ST_TICK0;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_UNW_WAIT: begin
            unw_q_in = unw_qprod[30:20];
            state_in = ST_UNW_FIX;
         end
         ST_UNW_FIX: begin
            yw_in    = yfix;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_we         = 1'b1;
            wdata.t        = cmd_ff.time_value;
            wdata.x        = cmd_ff.x;
            wdata.y        = cmd_ff.y;
            wdata.z        = cmd_ff.z;
            wdata.heading  = hd_sat;
            wdata.tilt     = 32'(cmd_ff.tilt);
            wdata.view     = 32'(cmd_ff.view);
            lasthd_in      = hd_sat;
            kc_in          = kc_ff + CW'(1);
            state_in       = ST_RESP;
         end
         ST_TICK0: begin
            adv_in   = tprod[46:12];
            raddr    = kcm1[AW-1:0];
            state_in = ST_TICK1;
         end
         ST_TICK1: begin
            state_in = ST_SMP0;
            if (tsum >= 36'(rd_ff.t)) begin
               if (cfg.loop_en) begin
                  if (rd_ff.t == '0) begin
                     pt_in = '0;
                     t_in  = '0;
                  end else begin
                     div_start = 1'b1;
                     div_dvd   = 48'(tsum);
                     div_dsr   = rd_ff.t;
                     state_in  = ST_MOD_WAIT;
                  end
               end else begin
                  pt_in   = rd_ff.t;
                  t_in    = rd_ff.t;
                  play_in = 1'b0;
               end
            end else begin
               pt_in = tsum[31:0];
               t_in  = tsum[31:0];
            end
         end
         ST_MOD_WAIT: begin
            if (div_done) begin
               pt_in    = div_rem;
               t_in     = div_rem;
               state_in = ST_SMP0;
            end
         end
         ST_SMP0: begin
            raddr    = '0;
            state_in = ST_SMP1;
         end
         ST_SMP1: begin
            prev_t_in = rd_ff.t;
            if (kc_ff == CW'(1) || t_ff <= rd_ff.t) begin
               pvalid_in = 1'b1;
               for (int k = 0; k < 6; k++) begin
                  pose_in[k] = chan_sel(rd_ff, 3'(k));
               end
               state_in = ST_RESP;
            end else begin
               raddr    = kcm1[AW-1:0];
               state_in = ST_SMP2;
            end
         end
         ST_SMP2: begin
            if (t_ff >= rd_ff.t) begin
               pvalid_in = 1'b1;
               for (int k = 0; k < 6; k++) begin
                  pose_in[k] = chan_sel(rd_ff, 3'(k));
               end
               state_in = ST_RESP;
            end else begin
               seg_in   = '0;
               raddr    = AW'(1);
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (rd_ff.t <= t_ff) begin
               prev_t_in = rd_ff.t;
               seg_in    = seg_ff + AW'(1);
               raddr     = seg_p2[AW-1:0];
            end else if (rd_ff.t > prev_t_ff) begin
               div_start = 1'b1;
               div_dvd   = {t_ff - prev_t_ff, 16'd0};
               div_dsr   = rd_ff.t - prev_t_ff;
               state_in  = ST_U_WAIT;
            end else begin
               u_in     = '0;
               state_in = ST_F0;
            end
         end
         ST_U_WAIT: begin
            if (div_done) begin
               u_in     = div_quo[15:0];
               state_in = ST_F0;
            end
         end
         ST_F0: begin
            raddr    = (seg_ff == '0) ? '0 : seg_ff - AW'(1);
            state_in = ST_F1;
         end
         ST_F1: begin
            p_in[0]  = rd_ff;
            raddr    = seg_ff;
            state_in = ST_F2;
         end
         ST_F2: begin
            p_in[1]  = rd_ff;
            raddr    = seg_ff + AW'(1);
            state_in = ST_F3;
         end
         ST_F3: begin
            p_in[2]  = rd_ff;
            raddr    = (seg_p2 < (CW + 1)'(kc_ff)) ? seg_p2[AW-1:0] : kcm1[AW-1:0];
            state_in = ST_F4;
         end
         ST_F4: begin
            p_in[3]  = rd_ff;
            ch_in    = '0;
            state_in = ST_SPL_INIT;
         end
         ST_SPL_INIT: begin
            acc_in   = 39'(c3);
            step_in  = '0;
            state_in = ST_SPL_MUL;
         end
         ST_SPL_MUL: begin
            prod_in  = acc_ff * $signed({1'b0, u_ff});
            state_in = ST_SPL_ADD;
         end
         ST_SPL_ADD: begin
            if (step_ff == 2'd2) begin
               pose_in[ch_ff] = sat32(40'(acc_half));
               if (ch_ff == 3'd5) begin
                  pvalid_in = 1'b1;
                  state_in  = ST_RESP;
               end else begin
                  ch_in    = ch_ff + 3'd1;
                  state_in = ST_SPL_INIT;
               end
            end else begin
               acc_in   = acc_new;
               step_in  = step_ff + 2'd1;
               state_in = ST_SPL_MUL;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kc_ff        <= '0;
         pt_ff        <= '0;
         play_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kc_ff        <= kc_in;
         pt_ff        <= pt_in;
         play_ff      <= play_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      lasthd_ff  <= lasthd_in;
      yw_ff      <= yw_in;
      unw_neg_ff <= unw_neg_in;
      unw_m_ff   <= unw_m_in;
      unw_q_ff   <= unw_q_in;
      adv_ff     <= adv_in;
      t_ff       <= t_in;
      prev_t_ff  <= prev_t_in;
      seg_ff     <= seg_in;
      u_ff       <= u_in;
      ch_ff      <= ch_in;
      step_ff    <= step_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      pvalid_ff  <= pvalid_in;
      for (int k = 0; k < 4; k++) begin
         p_ff[k] <= p_in[k];
      end
      for (int k = 0; k < 6; k++) begin
         pose_ff[k] <= pose_in[k];
      end
      if (rsp_load) begin
         rsp_pvalid_ff <= pvalid_ff;
         rsp_pt_ff     <= pt_ff;
         rsp_play_ff   <= play_ff;
         rsp_kc_ff     <= kc_ff;
         for (int k = 0; k < 6; k++) begin
            rsp_pose_ff[k] <= pose_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[kc_ff[AW-1:0]] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pose_valid      = rsp_pvalid_ff;
   assign rsp_pose_x          = rsp_pose_ff[0];
   assign rsp_pose_y          = rsp_pose_ff[1];
   assign rsp_pose_z          = rsp_pose_ff[2];
   assign rsp_pose_heading    = rsp_pose_ff[3];
   assign rsp_pose_tilt       = rsp_pose_ff[4];
   assign rsp_pose_view_angle = rsp_pose_ff[5];
   assign rsp_playhead        = rsp_pt_ff;
   assign rsp_is_playing      = rsp_play_ff;
   assign rsp_key_total       = rsp_kc_ff;

endmodule

[hw/rtl/keyframe_spline_pose_player_core.sv]
// Top level of the keyframe spline pose player: configuration registers,
// front end queue and back end engine. Uses kfsp_pkg, kfsp_front, kfsp_back.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     operation, time, key fields
//   rsp      out        rsp_valid / rsp_stall     pose, playhead, status
//   csr      in         csr_write_enable          csr_index, csr_write_data
//
// Engine: clear, start, an idle tick and unused codes go straight to the
// response; an append may unwrap the heading first. A sample reads end keys,
// then inside a segment runs a linear search, a divide for u and six spline
// channels. A tick advances the playhead; a looping wrap takes a modulo divide.
// Reset is synchronous and clears counts and flags; the table is not cleared.
// Two transactions queue ahead of the engine; a stalled response holds.
`timescale 1ns / 1ps
module keyframe_spline_pose_player_core
   import kfsp_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEF,
   localparam int CW = $clog2(MAX_KEYS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [14:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic [31:0]        req_time_value,
   input  logic signed [31:0] req_key_x,
   input  logic signed [31:0] req_key_y,
   input  logic signed [31:0] req_key_z,
   input  logic signed [24:0] req_key_heading,
   input  logic signed [23:0] req_key_tilt,
   input  logic [23:0]        req_key_view_angle,
   input  logic               req_allow_play,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_pose_valid,
   output logic signed [31:0] rsp_pose_x,
   output logic signed [31:0] rsp_pose_y,
   output logic signed [31:0] rsp_pose_z,
   output logic signed [31:0] rsp_pose_heading,
   output logic signed [31:0] rsp_pose_tilt,
   output logic signed [31:0] rsp_pose_view_angle,
   output logic [31:0]        rsp_playhead,
   output logic               rsp_is_playing,
   output logic [CW-1:0]      rsp_key_total
);

   cfg_type cfg_ff, cfg_in;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PLAY_SPEED:  cfg_in.speed   = csr_write_data;
            CSR_LOOP_ENABLE: cfg_in.loop_en = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed   <= PLAY_SPEED_RST;
         cfg_ff.loop_en <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kfsp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_time_value     (req_time_value),
      .req_key_x          (req_key_x),
      .req_key_y          (req_key_y),
      .req_key_z          (req_key_z),
      .req_key_heading    (req_key_heading),
      .req_key_tilt       (req_key_tilt),
      .req_key_view_angle (req_key_view_angle),
      .req_allow_play     (req_allow_play),
      .q_pop              (q_pop),
      .q_valid            (q_valid),
      .q_head             (q_head)
   );

   kfsp_back #(
      .MAX_KEYS (MAX_KEYS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .q_valid             (q_valid),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pose_valid      (rsp_pose_valid),
      .rsp_pose_x          (rsp_pose_x),
      .rsp_pose_y          (rsp_pose_y),
      .rsp_pose_z          (rsp_pose_z),
      .rsp_pose_heading    (rsp_pose_heading),
      .rsp_pose_tilt       (rsp_pose_tilt),
      .rsp_pose_view_angle (rsp_pose_view_angle),
      .rsp_playhead        (rsp_playhead),
      .rsp_is_playing      (rsp_is_playing),
      .rsp_key_total       (rsp_key_total)
   );

endmodule

[sim/tb_keyframe_spline_pose_player_core.sv]
// Testbench for keyframe_spline_pose_player_core: directed and random
// transactions checked against an in-bench pose predictor. Uses kfsp_pkg.
`timescale 1ns / 1ps
module tb_keyframe_spline_pose_player_core;
   import kfsp_pkg::*;

   localparam int NKEYS = MAX_KEYS_DEF;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      logic        pv;
      logic [31:0] p[6];
      logic [31:0] ph;
      logic        pl;
      logic [6:0]  kt;
   } pose_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic csr_index = 0;
   logic [14:0] csr_write_data = 0;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_operation = 0;
   logic [31:0] req_time_value = 0;
   logic signed [31:0] req_key_x = 0, req_key_y = 0, req_key_z = 0;
   logic signed [24:0] req_key_heading = 0;
   logic signed [23:0] req_key_tilt = 0;
   logic [23:0] req_key_view_angle = 0;
   logic req_allow_play = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_pose_valid;
   logic signed [31:0] rsp_pose_x, rsp_pose_y, rsp_pose_z;
   logic signed [31:0] rsp_pose_heading, rsp_pose_tilt, rsp_pose_view_angle;
   logic [31:0] rsp_playhead;
   logic rsp_is_playing;
   logic [6:0] rsp_key_total;

   keyframe_spline_pose_player_core DUT (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [31:0] m_time[NKEYS];
   logic signed [31:0] m_chan[NKEYS][6];
   int unsigned m_count = 0;
   logic [31:0] m_play = 0;
   logic m_run = 0;
   logic [14:0] m_speed = PLAY_SPEED_RST;
   logic m_loop = 0;

   pose_rsp_type expected_poses[$];
   int errors = 0;
   longint cycles = 0;
   bit rx_idle_en = 1, tx_idle_en = 1, hold_rx = 0;
   int unsigned rx_total = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic longint floor_sh16(longint v);
      return v >>> 16;
   endfunction

   function automatic logic [31:0] sat_32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic logic [31:0] catmull(longint p0, longint p1, longint p2,
                                           longint p3, longint u);
      longint c0, c1, c2, c3, acc;
      c0 = 2 * p1;
      c1 = p2 - p0;
      c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c3 = -p0 + 3 * p1 - 3 * p2 + p3;
      acc = floor_sh16(c3 * u) + c2;
      acc = floor_sh16(acc * u) + c1;
      acc = floor_sh16(acc * u) + c0;
      return sat_32(acc >>> 1);
   endfunction

   function automatic void sample_pose(logic [31:0] t, ref pose_rsp_type r);
      int unsigned n, i, i0, i3;
      longint u;
      n = m_count;
      i = 0;
      u = 0;
      if (n == 1 || t <= m_time[0]) begin
         for (int c = 0; c < 6; c++) r.p[c] = m_chan[0][c];
         return;
      end
      if (t >= m_time[n-1]) begin
         for (int c = 0; c < 6; c++) r.p[c] = m_chan[n-1][c];
         return;
      end
      while (i < n - 1 && m_time[i+1] <= t) i++;
      if (m_time[i+1] > m_time[i])
         u = ((longint'(t - m_time[i])) << 16) / longint'(m_time[i+1] - m_time[i]);
      i0 = (i > 0) ? i - 1 : 0;
      i3 = (i + 2 < n) ? i + 2 : n - 1;
      for (int c = 0; c < 6; c++)
         r.p[c] = catmull(m_chan[i0][c], m_chan[i][c], m_chan[i+1][c],
                          m_chan[i3][c], u);
   endfunction

   function automatic pose_rsp_type predict_pose(logic [2:0] op, logic [31:0] tv,
         logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
         logic signed [24:0] hd, logic signed [23:0] tl, logic [23:0] va,
         logic ap);
      pose_rsp_type r;
      longint yaw, d, tmax, t;
      r.pv = 0;
      for (int c = 0; c < 6; c++) r.p[c] = 0;
      case (op)
         OPC_CLEAR: begin
            m_count = 0;
            m_play = 0;
            m_run = 0;
         end
         OPC_APPEND: if (m_count < NKEYS) begin
            yaw = hd;
            if (m_count > 0) begin
               d = yaw - longint'(m_chan[m_count-1][3]);
               if (d > DEG180)
                  yaw -= ((d - DEG180 + DEG360 - 1) / DEG360) * DEG360;
               else if (d < -DEG180)
                  yaw += ((-DEG180 - d + DEG360 - 1) / DEG360) * DEG360;
            end
            m_time[m_count] = tv;
            m_chan[m_count][0] = x;
            m_chan[m_count][1] = y;
            m_chan[m_count][2] = z;
            m_chan[m_count][3] = sat_32(yaw);
            m_chan[m_count][4] = 32'(tl);
            m_chan[m_count][5] = {8'd0, va};
            m_count++;
         end
         OPC_SAMPLE: begin
            m_play = tv;
            m_run = 0;
            if (m_count > 0) begin
               sample_pose(tv, r);
               r.pv = 1;
            end
         end
         OPC_START: if (m_count >= 2) begin
            m_run = 1;
            m_play = 0;
         end
         OPC_TICK: if (ap && m_run && m_count >= 2) begin
            tmax = m_time[m_count-1];
            t = longint'(m_play) + ((longint'(tv) * longint'(m_speed)) >>> 12);
            if (t >= tmax) begin
               if (m_loop) t = (tmax == 0) ? 0 : t % tmax;
               else begin
                  t = tmax;
                  m_run = 0;
               end
            end
            m_play = t[31:0];
            sample_pose(m_play, r);
            r.pv = 1;
         end
         default: ;
      endcase
      r.ph = m_play;
      r.pl = m_run;
      r.kt = m_count[6:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
      errors++;
   endtask

   // response checker
   always @(posedge clock) begin
      pose_rsp_type e;
      logic [31:0] g[6];
      if (!reset && rsp_valid && !rsp_stall) begin
         rx_total++;
         if (expected_poses.size() == 0)
            report_mismatch("unexpected transaction", 0, 0);
         else begin
            e = expected_poses.pop_front();
            g = '{rsp_pose_x, rsp_pose_y, rsp_pose_z, rsp_pose_heading,
                  rsp_pose_tilt, rsp_pose_view_angle};
            if (rsp_pose_valid !== e.pv) report_mismatch("pose_valid", rsp_pose_valid, e.pv);
            for (int c = 0; c < 6; c++)
               if (g[c] !== e.p[c]) report_mismatch($sformatf("pose[%0d]", c), g[c], e.p[c]);
            if (rsp_playhead !== e.ph) report_mismatch("playhead", rsp_playhead, e.ph);
            if (rsp_is_playing !== e.pl) report_mismatch("is_playing", rsp_is_playing, e.pl);
            if (rsp_key_total !== e.kt) report_mismatch("key_total", rsp_key_total, e.kt);
         end
      end
   end

   // receiver stall in random bursts
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_rx) begin
            rsp_stall <= 1;
            @(posedge clock);
         end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 11);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            @(posedge clock);
         end
      end
   end

   task automatic send_op(logic [2:0] op, logic [31:0] tv = 0,
         logic signed [31:0] x = 0, logic signed [31:0] y = 0,
         logic signed [31:0] z = 0, logic signed [24:0] hd = 0,
         logic signed [23:0] tl = 0, logic [23:0] va = 0, logic ap = 1);
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_time_value <= tv;
      req_key_x <= x;
      req_key_y <= y;
      req_key_z <= z;
      req_key_heading <= hd;
      req_key_tilt <= tl;
      req_key_view_angle <= va;
      req_allow_play <= ap;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_poses = {expected_poses, predict_pose(op, tv, x, y, z, hd, tl, va, ap)};
   endtask

   task automatic drain_all();
      req_valid <= 0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [14:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      if (idx == CSR_PLAY_SPEED) m_speed = val;
      else m_loop = val[0];
      @(posedge clock);
   endtask

   task automatic append_random(logic [31:0] t);
      send_op(OPC_APPEND, t, $urandom, $urandom, $urandom,
              25'($signed($urandom_range(0, 23592960)) - 11796480),
              24'($signed($urandom_range(0, 11796480)) - 5898240),
              24'($urandom_range(0, 11796480)));
   endtask

   task automatic test_directed();
      send_op(OPC_SAMPLE, 32'h1234);
      send_op(OPC_START);
      send_op(OPC_TICK, 32'h10000);
      send_op(3'd5);
      send_op(3'd7, 32'hFFFFFFFF);
      send_op(OPC_APPEND, 0, 32'h7FFFFFFF, 32'h80000000, 0, 25'sd11796480,
              24'sd5898240, 24'd11796480);
      send_op(OPC_START);
      send_op(OPC_SAMPLE, 32'h5000);
      send_op(OPC_APPEND, 32'h10000, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
              -25'sd11796480, -24'sd5898240, 24'd0);
      send_op(OPC_APPEND, 32'h10000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              25'sd11796480, 24'sd5898240, 24'hFFFFFF);
      send_op(OPC_APPEND, 32'h30000, 32'h80000000, 32'h7FFFFFFF, 0,
              -25'sd11796480, 24'sd0, 24'd100);
      send_op(OPC_SAMPLE, 32'h10000);
      send_op(OPC_SAMPLE, 32'h20000);
      send_op(OPC_SAMPLE, 32'hFFFFFFFF);
      send_op(OPC_START);
      send_op(OPC_TICK, 32'h8000, 0, 0, 0, 0, 0, 0, 0);
      send_op(OPC_TICK, 32'h8000);
      send_op(OPC_TICK, 32'hFFFFFFFF);
      send_op(OPC_TICK, 32'h1000);
      send_op(OPC_CLEAR);
      send_op(OPC_APPEND, 32'hFFFFFFFF, 0, 0, 0, 25'h1FFFFFF, 24'h800000, 24'hFFFFFF);
      drain_all();
   endtask

   task automatic test_full_table();
      send_op(OPC_CLEAR);
      for (int k = 0; k < NKEYS + 2; k++) append_random(32'(k) << 12);
      send_op(OPC_SAMPLE, 32'h20800);
      send_op(OPC_SAMPLE, 32'h3F000);
      drain_all();
   endtask

   task automatic test_loop_play(logic [14:0] spd, logic lp);
      write_csr(CSR_PLAY_SPEED, spd);
      write_csr(CSR_LOOP_ENABLE, lp);
      send_op(OPC_CLEAR);
      for (int k = 0; k < 4; k++) append_random(32'(k * $urandom_range(0, 3)) << 14);
      send_op(OPC_START);
      for (int k = 0; k < 12; k++) send_op(OPC_TICK, $urandom_range(0, 32'h8000));
      drain_all();
   endtask

   task automatic test_backpressure();
      hold_rx = 1;
      fork
         begin
            int n;
            n = 0;
            while (n < 400) begin
               @(posedge clock);
               n++;
            end
            hold_rx = 0;
         end
         for (int k = 0; k < 10; k++) send_op(OPC_SAMPLE, $urandom);
      join
      drain_all();
   endtask

   task automatic test_random(int items);
      logic [31:0] t;
      int r;
      for (int k = 0; k < items; k++) begin
         if (k > items * 3 / 4) begin
            tx_idle_en = 0;
            rx_idle_en = 0;
         end
         if (k % 60 == 0) begin
            send_op(OPC_CLEAR);
            t = 0;
            repeat ($urandom_range(1, 8)) begin
               t += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 32'h30000);
               append_random(t);
            end
            send_op(OPC_START);
         end
         r = $urandom_range(0, 19);
         if (r < 7) send_op(OPC_TICK, $urandom_range(0, 32'h20000), 0, 0, 0, 0, 0, 0,
                            $urandom_range(0, 5) != 0);
         else if (r < 13) send_op(OPC_SAMPLE, ($urandom_range(0, 3) == 0) ? $urandom
                                  : $urandom_range(0, t + 32'h10000));
         else if (r < 15) send_op(OPC_START);
         else if (r < 17) begin
            t += $urandom_range(0, 32'h20000);
            append_random(($urandom_range(0, 7) == 0) ? $urandom : t);
         end else if (r < 18) send_op(3'($urandom_range(5, 7)), $urandom);
         else send_op(OPC_APPEND, t, $urandom, $urandom, $urandom, 25'($urandom),
                      24'($urandom), 24'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_loop_play(15'd410, 1);
      test_loop_play(15'd16384, 0);
      test_loop_play(15'h7FFF, 1);
      test_backpressure();
      write_csr(CSR_PLAY_SPEED, 15'd4096);
      write_csr(CSR_LOOP_ENABLE, 1);
      test_random(250);
      drain_all();
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
